FILE: rtl/core/pcp_pkg.sv
`timescale 1ns / 1ps

package pcp_pkg;

    localparam int ROWS        = 16;
    localparam int COLUMNS     = 64;
    localparam int GROUP_LIMIT = 29;
    localparam int GROUP_W     = $clog2(GROUP_LIMIT + 1);

    // result queue depth in bytes, each entry holds up to two results
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] CH_NUL     = 8'h00;
    localparam logic [7:0] CH_OPEN_SQ = 8'h5B;
    localparam logic [7:0] CH_CLOSE_SQ = 8'h5D;
    localparam logic [7:0] CH_OPEN    = 8'h28;
    localparam logic [7:0] CH_CLOSE   = 8'h29;
    localparam logic [7:0] CH_COMMA   = 8'h2C;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_HASH    = 8'h23;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_X_LOWER = 8'h78;
    localparam logic [7:0] CH_X_UPPER = 8'h58;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_CR      = 8'h0D;

    typedef enum logic [1:0] {
        KIND_PIXEL = 2'd0,
        KIND_CLEAR = 2'd1,
        KIND_SHOW  = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        PH_START  = 3'd0,
        PH_BODY   = 3'd1,
        PH_SIGN   = 3'd2,
        PH_ZERO   = 3'd3,
        PH_DIGITS = 3'd4,
        PH_HEXPFX = 3'd5,
        PH_DONE   = 3'd7
    } t_phase;

    typedef struct packed {
        t_kind       kind;
        logic [3:0]  row;
        logic [5:0]  column;
        logic [31:0] colour;
        logic        last_result;
    } t_result;

    typedef struct packed {
        logic    two;
        t_result first;
        t_result second;
    } t_entry;

    typedef struct packed {
        logic       valid;
        logic [3:0] value;
    } t_hex;

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic t_hex hex_digit(input logic [7:0] c);
        t_hex h;
        h.valid = 1'b1;
        h.value = c[3:0];
        if (c >= 8'h30 && c <= 8'h39) begin
            h.value = c[3:0];
        end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
            h.value = c[3:0] + 4'd9;
        end else begin
            h.valid = 1'b0;
        end
        return h;
    endfunction

endpackage

FILE: rtl/core/pcp_if.sv
`timescale 1ns / 1ps

interface pcp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       first_byte;
    logic       clear_frame;
    logic       last_byte;

    modport source (output valid, output data_byte, output first_byte,
                    output clear_frame, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input first_byte,
                    input clear_frame, input last_byte, output ready);
endinterface

interface pcp_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [3:0]  row;
    logic [5:0]  column;
    logic [31:0] colour;
    logic        last_result;

    modport source (output valid, output kind, output row, output column,
                    output colour, output last_result, input ready);
    modport sink   (input valid, input kind, input row, input column,
                    input colour, input last_result, output ready);
endinterface

FILE: rtl/core/pixel_command_parser.sv
`timescale 1ns / 1ps

// pixel command parser
// i_in carries one character of a command chunk per item, with first_byte,
// clear_frame and last_byte marks. o_res carries the results: pixel writes,
// frame clears and frame shows, with last_result on the final result of a byte.
// each accepted byte is parsed in the cycle it is accepted; its results are
// registered in the result queue and offered on o_res once earlier results are taken.
// a byte gives zero, one or two results. one byte can be taken every cycle while the
// queue is not full; a byte with two results offers them on o_res one after the other, so
// sustained throughput is set by the output side at one result per cycle while o_res.ready is high.
// results wait in a two-entry queue (one entry per byte that gives results); i_in.ready drops only
// when both entries hold undelivered results, so a stalled receiver pushes
// back after two bytes that give results.
// reset (synchronous, active low) clears the parse state and empties the queue.
module pixel_command_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pcp_in_if.sink      i_in,
    pcp_out_if.source   o_res
);

    logic                          r_seen_open, n_seen_open;
    logic                          r_seen_close, n_seen_close;
    logic                          r_in_group, n_in_group;
    logic [pcp_pkg::GROUP_W-1:0]   r_group_chars, n_group_chars;
    logic [1:0]                    r_field_number, n_field_number;
    pcp_pkg::t_phase               r_number_phase, n_number_phase;
    logic                          r_number_negative, n_number_negative;
    logic                          r_coord_reject, n_coord_reject;
    logic                          r_colour_over, n_colour_over;
    logic [15:0]                   r_row_value, n_row_value;
    logic [15:0]                   r_column_value, n_column_value;
    logic [31:0]                   r_colour_value, n_colour_value;

    // state as seen by this byte (first_byte restarts the parse)
    logic                          e_seen_open, e_seen_close, e_in_group;
    logic [pcp_pkg::GROUP_W-1:0]   e_group_chars;
    logic [1:0]                    e_field_number;
    pcp_pkg::t_phase               e_number_phase;
    logic                          e_number_negative, e_coord_reject, e_colour_over;
    logic [15:0]                   e_row_value, e_column_value;
    logic [31:0]                   e_colour_value;

    logic [7:0]                    c;
    logic                          accept;
    logic [15:0]                   dec_src;
    logic [19:0]                   dec_wide;
    logic [15:0]                   dec_sat;
    pcp_pkg::t_hex                 hx;
    logic                          pix_emit, show_emit, clear_emit;
    logic                          do_sign, do_digits;
    pcp_pkg::t_phase               ph;
    logic [31:0]                   pix_colour;
    pcp_pkg::t_result              res_pixel, res_clear, res_show;
    pcp_pkg::t_entry               new_entry;
    logic [1:0]                    res_count;

    pcp_pkg::t_entry               r_queue [pcp_pkg::QUEUE_DEPTH];
    logic [pcp_pkg::QUEUE_AW-1:0]  r_wr_ptr, r_rd_ptr;
    logic [pcp_pkg::QUEUE_CW-1:0]  r_count;
    logic                          r_sub;
    pcp_pkg::t_entry               head;
    logic                          push, out_fire, pop;

    assign c      = i_in.data_byte;
    assign accept = i_in.valid && i_in.ready;

    always_comb begin
        e_seen_open       = r_seen_open;
        e_seen_close      = r_seen_close;
        e_in_group        = r_in_group;
        e_group_chars     = r_group_chars;
        e_field_number    = r_field_number;
        e_number_phase    = r_number_phase;
        e_number_negative = r_number_negative;
        e_coord_reject    = r_coord_reject;
        e_colour_over     = r_colour_over;
        e_row_value       = r_row_value;
        e_column_value    = r_column_value;
        e_colour_value    = r_colour_value;
        if (i_in.first_byte) begin
            e_seen_open       = 1'b0;
            e_seen_close      = 1'b0;
            e_in_group        = 1'b0;
            e_group_chars     = '0;
            e_field_number    = 2'd0;
            e_number_phase    = pcp_pkg::PH_START;
            e_number_negative = 1'b0;
            e_coord_reject    = 1'b0;
            e_colour_over     = 1'b0;
            e_row_value       = 16'd0;
            e_column_value    = 16'd0;
            e_colour_value    = 32'd0;
        end
    end

    // decimal step: v * 10 + digit, saturating at 16 bits
    assign dec_src  = (e_field_number == 2'd0) ? e_row_value : e_column_value;
    assign dec_wide = ({4'd0, dec_src} << 3) + ({4'd0, dec_src} << 1) + {16'd0, c[3:0]};
    assign dec_sat  = (dec_wide[19:16] != 4'd0) ? 16'hFFFF : dec_wide[15:0];
    assign hx       = pcp_pkg::hex_digit(c);

    always_comb begin
        n_seen_open       = e_seen_open;
        n_seen_close      = e_seen_close;
        n_in_group        = e_in_group;
        n_group_chars     = e_group_chars;
        n_field_number    = e_field_number;
        n_number_phase    = e_number_phase;
        n_number_negative = e_number_negative;
        n_coord_reject    = e_coord_reject;
        n_colour_over     = e_colour_over;
        n_row_value       = e_row_value;
        n_column_value    = e_column_value;
        n_colour_value    = e_colour_value;
        pix_emit          = 1'b0;
        do_sign           = 1'b0;
        do_digits         = 1'b0;
        ph                = e_number_phase;

        if (!e_seen_close) begin
            if (!e_seen_open) begin
                if (c == pcp_pkg::CH_OPEN_SQ) begin
                    n_seen_open = 1'b1;
                end else if (c == pcp_pkg::CH_NUL) begin
                    n_seen_close = 1'b1;
                end
            end else if (c == pcp_pkg::CH_CLOSE_SQ || c == pcp_pkg::CH_NUL) begin
                n_seen_close = 1'b1;
            end else if (c == pcp_pkg::CH_OPEN) begin
                n_in_group        = 1'b1;
                n_group_chars     = '0;
                n_field_number    = 2'd0;
                n_number_phase    = pcp_pkg::PH_START;
                n_number_negative = 1'b0;
                n_coord_reject    = 1'b0;
                n_colour_over     = 1'b0;
                n_row_value       = 16'd0;
                n_column_value    = 16'd0;
                n_colour_value    = 32'd0;
            end else if (c == pcp_pkg::CH_CLOSE) begin
                if (e_in_group) begin
                    n_in_group = 1'b0;
                    pix_emit = (e_field_number == 2'd2) && !e_coord_reject &&
                               (e_row_value < 16'(pcp_pkg::ROWS)) &&
                               (e_column_value < 16'(pcp_pkg::COLUMNS));
                end
            end else if (e_in_group &&
                         e_group_chars < pcp_pkg::GROUP_W'(pcp_pkg::GROUP_LIMIT)) begin
                n_group_chars = e_group_chars + pcp_pkg::GROUP_W'(1);
                if (e_field_number < 2'd2 && c == pcp_pkg::CH_COMMA) begin
                    n_field_number    = e_field_number + 2'd1;
                    n_number_phase    = pcp_pkg::PH_START;
                    n_number_negative = 1'b0;
                end else if (e_field_number < 2'd2) begin
                    // row or column, read like atoi
                    case (e_number_phase)
                        pcp_pkg::PH_START: begin
                            if (pcp_pkg::is_blank(c)) begin
                                n_number_phase = pcp_pkg::PH_START;
                            end else if (c == pcp_pkg::CH_PLUS) begin
                                n_number_phase = pcp_pkg::PH_BODY;
                            end else if (c == pcp_pkg::CH_MINUS) begin
                                n_number_negative = 1'b1;
                                n_number_phase    = pcp_pkg::PH_BODY;
                            end else if (pcp_pkg::is_digit(c)) begin
                                do_digits      = 1'b1;
                                n_number_phase = pcp_pkg::PH_BODY;
                            end else begin
                                n_number_phase = pcp_pkg::PH_DONE;
                            end
                        end
                        pcp_pkg::PH_BODY: begin
                            if (pcp_pkg::is_digit(c)) begin
                                do_digits = 1'b1;
                            end else begin
                                n_number_phase = pcp_pkg::PH_DONE;
                            end
                        end
                        default: begin
                            n_number_phase = e_number_phase;
                        end
                    endcase
                    if (do_digits) begin
                        if (e_field_number == 2'd0) begin
                            n_row_value = dec_sat;
                        end else begin
                            n_column_value = dec_sat;
                        end
                        if (e_number_negative && dec_sat != 16'd0) begin
                            n_coord_reject = 1'b1;
                        end
                    end
                end else begin
                    // colour, read like strtoul base 16 after an optional '#'
                    if (ph == pcp_pkg::PH_START) begin
                        ph = pcp_pkg::PH_BODY;
                    end
                    n_number_phase = ph;
                    if (!(e_number_phase == pcp_pkg::PH_START && c == pcp_pkg::CH_HASH)) begin
                        case (ph)
                            pcp_pkg::PH_BODY: begin
                                if (pcp_pkg::is_blank(c)) begin
                                    n_number_phase = pcp_pkg::PH_BODY;
                                end else if (c == pcp_pkg::CH_PLUS) begin
                                    n_number_phase = pcp_pkg::PH_SIGN;
                                end else if (c == pcp_pkg::CH_MINUS) begin
                                    n_number_negative = 1'b1;
                                    n_number_phase    = pcp_pkg::PH_SIGN;
                                end else begin
                                    do_sign = 1'b1;
                                end
                            end
                            pcp_pkg::PH_SIGN: begin
                                do_sign = 1'b1;
                            end
                            pcp_pkg::PH_ZERO: begin
                                if (c == pcp_pkg::CH_X_LOWER || c == pcp_pkg::CH_X_UPPER) begin
                                    n_number_phase = pcp_pkg::PH_HEXPFX;
                                end else begin
                                    do_digits = 1'b1;
                                end
                            end
                            pcp_pkg::PH_DIGITS, pcp_pkg::PH_HEXPFX: begin
                                do_digits = 1'b1;
                            end
                            default: begin
                                n_number_phase = ph;
                            end
                        endcase
                        if (do_sign) begin
                            if (c == pcp_pkg::CH_ZERO) begin
                                n_number_phase = pcp_pkg::PH_ZERO;
                            end else begin
                                do_digits = 1'b1;
                            end
                        end
                        if (do_digits) begin
                            if (hx.valid) begin
                                n_number_phase = pcp_pkg::PH_DIGITS;
                                if (!e_colour_over) begin
                                    if (e_colour_value[31:28] != 4'd0) begin
                                        n_colour_over  = 1'b1;
                                        n_colour_value = 32'hFFFF_FFFF;
                                    end else begin
                                        n_colour_value = {e_colour_value[27:0], hx.value};
                                    end
                                end
                            end else begin
                                n_number_phase = pcp_pkg::PH_DONE;
                            end
                        end
                    end
                end
            end
        end

        show_emit = i_in.last_byte && n_seen_open;
        if (i_in.last_byte) begin
            n_seen_open       = 1'b0;
            n_seen_close      = 1'b0;
            n_in_group        = 1'b0;
            n_group_chars     = '0;
            n_field_number    = 2'd0;
            n_number_phase    = pcp_pkg::PH_START;
            n_number_negative = 1'b0;
            n_coord_reject    = 1'b0;
            n_colour_over     = 1'b0;
            n_row_value       = 16'd0;
            n_column_value    = 16'd0;
            n_colour_value    = 32'd0;
        end
    end

    assign clear_emit = i_in.first_byte && i_in.clear_frame;
    assign pix_colour = e_colour_over ? 32'hFFFF_FFFF :
                        (e_number_negative ? (32'd0 - e_colour_value) : e_colour_value);

    always_comb begin
        res_clear = '{kind: pcp_pkg::KIND_CLEAR, row: 4'd0, column: 6'd0,
                      colour: 32'd0, last_result: 1'b0};
        res_show  = '{kind: pcp_pkg::KIND_SHOW, row: 4'd0, column: 6'd0,
                      colour: 32'd0, last_result: 1'b1};
        res_pixel = '{kind: pcp_pkg::KIND_PIXEL, row: e_row_value[3:0],
                      column: e_column_value[5:0], colour: pix_colour, last_result: 1'b0};
        res_count = 2'({1'b0, clear_emit} + {1'b0, pix_emit} + {1'b0, show_emit});
        // a byte never gives both a clear and a pixel write
        if (clear_emit) begin
            new_entry.first = res_clear;
        end else if (pix_emit) begin
            new_entry.first = res_pixel;
        end else begin
            new_entry.first = res_show;
        end
        new_entry.first.last_result = (res_count == 2'd1);
        new_entry.second = res_show;
        new_entry.two    = (res_count == 2'd2);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen_open       <= 1'b0;
            r_seen_close      <= 1'b0;
            r_in_group        <= 1'b0;
            r_group_chars     <= '0;
            r_field_number    <= 2'd0;
            r_number_phase    <= pcp_pkg::PH_START;
            r_number_negative <= 1'b0;
            r_coord_reject    <= 1'b0;
            r_colour_over     <= 1'b0;
            r_row_value       <= 16'd0;
            r_column_value    <= 16'd0;
            r_colour_value    <= 32'd0;
        end else if (accept) begin
            r_seen_open       <= n_seen_open;
            r_seen_close      <= n_seen_close;
            r_in_group        <= n_in_group;
            r_group_chars     <= n_group_chars;
            r_field_number    <= n_field_number;
            r_number_phase    <= n_number_phase;
            r_number_negative <= n_number_negative;
            r_coord_reject    <= n_coord_reject;
            r_colour_over     <= n_colour_over;
            r_row_value       <= n_row_value;
            r_column_value    <= n_column_value;
            r_colour_value    <= n_colour_value;
        end
    end

    // result queue
    assign head       = r_queue[r_rd_ptr];
    assign push       = accept && (res_count != 2'd0);
    assign out_fire   = o_res.valid && o_res.ready;
    assign pop        = out_fire && (r_sub || !head.two);
    assign i_in.ready = (r_count != pcp_pkg::QUEUE_CW'(pcp_pkg::QUEUE_DEPTH));

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_queue[r_wr_ptr] <= new_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
            r_sub    <= 1'b0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + pcp_pkg::QUEUE_AW'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + pcp_pkg::QUEUE_AW'(1);
            end
            if (push && !pop) begin
                r_count <= r_count + pcp_pkg::QUEUE_CW'(1);
            end else if (pop && !push) begin
                r_count <= r_count - pcp_pkg::QUEUE_CW'(1);
            end
            if (out_fire) begin
                r_sub <= !pop;
            end
        end
    end

    pcp_pkg::t_result out_res;
    assign out_res            = r_sub ? head.second : head.first;
    assign o_res.valid        = (r_count != '0);
    assign o_res.kind         = out_res.kind;
    assign o_res.row          = out_res.row;
    assign o_res.column       = out_res.column;
    assign o_res.colour       = out_res.colour;
    assign o_res.last_result  = out_res.last_result;

endmodule

FILE: test/tb_pixel_command_parser.sv
`timescale 1ns / 1ps

module tb_pixel_command_parser;

    localparam int RANDOM_ITEMS   = 800;
    // longest quiet stretch is a sender gap plus a stalled receiver
    localparam int WATCHDOG_LIMIT = 200;
    localparam int DRAIN_CYCLES   = 8;

    logic i_clk = 1'b0;
    logic i_rst_n;

    always #1 i_clk = ~i_clk;

    pcp_in_if  in_ch ();
    pcp_out_if res_ch ();

    pixel_command_parser uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_res   (res_ch)
    );

    bit               idle_en;
    int unsigned      bytes_sent;
    int               fail_count;
    int               quiet_cycles;
    logic [7:0]       chunk_bytes[$];
    pcp_pkg::t_result expected_results[$];

    // mirror of the parse state
    logic            open_seen;
    logic            close_seen;
    logic            group_open;
    logic [4:0]      grp_count;
    logic [1:0]      field_idx;
    pcp_pkg::t_phase phase;
    logic            neg;
    logic            coord_bad;
    logic            hex_over;
    logic [15:0]     row_acc;
    logic [15:0]     col_acc;
    logic [31:0]     hex_acc;

    function automatic void clear_group();
        grp_count = '0;
        field_idx = '0;
        phase     = pcp_pkg::PH_START;
        neg       = 1'b0;
        coord_bad = 1'b0;
        hex_over  = 1'b0;
        row_acc   = '0;
        col_acc   = '0;
        hex_acc   = '0;
    endfunction

    function automatic void clear_parse();
        open_seen  = 1'b0;
        close_seen = 1'b0;
        group_open = 1'b0;
        clear_group();
    endfunction

    function automatic logic blank_char(logic [7:0] c);
        return (c == pcp_pkg::CH_SPACE) || (c >= pcp_pkg::CH_TAB && c <= pcp_pkg::CH_CR);
    endfunction

    // {valid, value}
    function automatic logic [4:0] hex_value(logic [7:0] c);
        logic [7:0] d;
        d = 8'hFF;
        if (c >= "0" && c <= "9") d = c - "0";
        else if (c >= "a" && c <= "f") d = c - "a" + 8'd10;
        else if (c >= "A" && c <= "F") d = c - "A" + 8'd10;
        return (d == 8'hFF) ? 5'd0 : {1'b1, d[3:0]};
    endfunction

    function automatic void add_decimal(logic [7:0] c);
        logic [31:0] t;
        logic [15:0] v;
        v = (field_idx == 2'd0) ? row_acc : col_acc;
        t = {16'b0, v} * 32'd10 + {24'b0, c - pcp_pkg::CH_ZERO};
        if (t > 32'd65535) t = 32'd65535;
        if (field_idx == 2'd0) row_acc = t[15:0];
        else col_acc = t[15:0];
        if (neg && t != 0) coord_bad = 1'b1;
    endfunction

    function automatic void feed_decimal(logic [7:0] c);
        logic digit;
        digit = (c >= "0" && c <= "9");
        if (phase == pcp_pkg::PH_START) begin
            if (blank_char(c)) return;
            if (c == pcp_pkg::CH_PLUS) begin
                phase = pcp_pkg::PH_BODY;
            end else if (c == pcp_pkg::CH_MINUS) begin
                neg   = 1'b1;
                phase = pcp_pkg::PH_BODY;
            end else if (digit) begin
                add_decimal(c);
                phase = pcp_pkg::PH_BODY;
            end else begin
                phase = pcp_pkg::PH_DONE;
            end
        end else if (phase == pcp_pkg::PH_BODY) begin
            if (digit) add_decimal(c);
            else phase = pcp_pkg::PH_DONE;
        end
    endfunction

    function automatic void add_hex(logic [3:0] h);
        logic [35:0] t;
        if (hex_over) return;
        t = {hex_acc, h};
        if (t[35:32] != 4'd0) begin
            hex_over = 1'b1;
            hex_acc  = '1;
        end else begin
            hex_acc = t[31:0];
        end
    endfunction

    function automatic void feed_colour(logic [7:0] c);
        logic [4:0] h;
        h = hex_value(c);
        if (phase == pcp_pkg::PH_START) begin
            phase = pcp_pkg::PH_BODY;
            if (c == pcp_pkg::CH_HASH) return;
        end
        if (phase == pcp_pkg::PH_BODY) begin
            if (blank_char(c)) return;
            if (c == pcp_pkg::CH_PLUS) begin
                phase = pcp_pkg::PH_SIGN;
                return;
            end
            if (c == pcp_pkg::CH_MINUS) begin
                neg   = 1'b1;
                phase = pcp_pkg::PH_SIGN;
                return;
            end
        end
        if (phase == pcp_pkg::PH_BODY || phase == pcp_pkg::PH_SIGN) begin
            if (c == pcp_pkg::CH_ZERO) begin
                phase = pcp_pkg::PH_ZERO;
            end else if (h[4]) begin
                add_hex(h[3:0]);
                phase = pcp_pkg::PH_DIGITS;
            end else begin
                phase = pcp_pkg::PH_DONE;
            end
            return;
        end
        // a leading zero may open a 0x prefix
        if (phase == pcp_pkg::PH_ZERO &&
            (c == pcp_pkg::CH_X_LOWER || c == pcp_pkg::CH_X_UPPER)) begin
            phase = pcp_pkg::PH_HEXPFX;
            return;
        end
        if (phase == pcp_pkg::PH_ZERO || phase == pcp_pkg::PH_DIGITS ||
            phase == pcp_pkg::PH_HEXPFX) begin
            if (h[4]) begin
                add_hex(h[3:0]);
                phase = pcp_pkg::PH_DIGITS;
            end else begin
                phase = pcp_pkg::PH_DONE;
            end
        end
    endfunction

    function automatic void feed_group(logic [7:0] c);
        if (grp_count >= pcp_pkg::GROUP_LIMIT) return;
        grp_count = grp_count + 5'd1;
        if (field_idx < 2'd2 && c == pcp_pkg::CH_COMMA) begin
            field_idx = field_idx + 2'd1;
            phase     = pcp_pkg::PH_START;
            neg       = 1'b0;
            return;
        end
        if (field_idx == 2'd2) feed_colour(c);
        else feed_decimal(c);
    endfunction

    function automatic pcp_pkg::t_result make_result(pcp_pkg::t_kind k, logic [3:0] rw,
                                                     logic [5:0] cl, logic [31:0] shade);
        pcp_pkg::t_result r;
        r.kind        = k;
        r.row         = rw;
        r.column      = cl;
        r.colour      = shade;
        r.last_result = 1'b0;
        return r;
    endfunction

    function automatic void predict_byte(logic [7:0] c, logic fb, logic cf, logic lb);
        pcp_pkg::t_result batch[$];
        logic [31:0]      shade;
        if (fb) begin
            clear_parse();
            if (cf) batch.push_back(make_result(pcp_pkg::KIND_CLEAR, 4'd0, 6'd0, 32'd0));
        end
        if (!close_seen) begin
            if (!open_seen) begin
                if (c == pcp_pkg::CH_OPEN_SQ) open_seen = 1'b1;
                else if (c == pcp_pkg::CH_NUL) close_seen = 1'b1;
            end else if (c == pcp_pkg::CH_CLOSE_SQ || c == pcp_pkg::CH_NUL) begin
                close_seen = 1'b1;
            end else if (c == pcp_pkg::CH_OPEN) begin
                group_open = 1'b1;
                clear_group();
            end else if (c == pcp_pkg::CH_CLOSE) begin
                if (group_open) begin
                    group_open = 1'b0;
                    if (field_idx == 2'd2 && !coord_bad && row_acc < pcp_pkg::ROWS &&
                        col_acc < pcp_pkg::COLUMNS) begin
                        if (hex_over) shade = '1;
                        else if (neg) shade = 32'd0 - hex_acc;
                        else shade = hex_acc;
                        batch.push_back(make_result(pcp_pkg::KIND_PIXEL, row_acc[3:0],
                                                    col_acc[5:0], shade));
                    end
                end
            end else if (group_open) begin
                feed_group(c);
            end
        end
        if (lb) begin
            if (open_seen) begin
                batch.push_back(make_result(pcp_pkg::KIND_SHOW, 4'd0, 6'd0, 32'd0));
            end
            clear_parse();
        end
        if (batch.size() > 0) batch[batch.size() - 1].last_result = 1'b1;
        foreach (batch[i]) expected_results.push_back(batch[i]);
    endfunction

    // byte accepted -> predict first so a result in the same edge still finds its entry
    always @(posedge i_clk) begin
        pcp_pkg::t_result want;
        if (i_rst_n) begin
            if (in_ch.valid === 1'b1 && in_ch.ready === 1'b1) begin
                predict_byte(in_ch.data_byte, in_ch.first_byte, in_ch.clear_frame,
                             in_ch.last_byte);
            end
            if (res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
                if (expected_results.size() == 0) begin
                    $error("unexpected result: kind %0d row %0d column %0d colour %h",
                           res_ch.kind, res_ch.row, res_ch.column, res_ch.colour);
                    fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (res_ch.kind !== want.kind) begin
                        $error("kind: expected %0d, got %0d", want.kind, res_ch.kind);
                        fail_count++;
                    end
                    if (res_ch.row !== want.row) begin
                        $error("row: expected %0d, got %0d", want.row, res_ch.row);
                        fail_count++;
                    end
                    if (res_ch.column !== want.column) begin
                        $error("column: expected %0d, got %0d", want.column, res_ch.column);
                        fail_count++;
                    end
                    if (res_ch.colour !== want.colour) begin
                        $error("colour: expected %h, got %h", want.colour, res_ch.colour);
                        fail_count++;
                    end
                    if (res_ch.last_result !== want.last_result) begin
                        $error("last_result: expected %0d, got %0d", want.last_result,
                               res_ch.last_result);
                        fail_count++;
                    end
                end
            end
            if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
                (res_ch.valid === 1'b1 && res_ch.ready === 1'b1)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("tb_pixel_command_parser failed");
                $finish;
            end
        end
    end

    // result side: a random hold before each item while idle_en is set
    initial begin
        int unsigned hold;
        res_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            hold = idle_en ? $urandom_range(0, 6) : 0;
            if (hold > 0) begin
                res_ch.ready <= 1'b0;
                repeat (hold) @(negedge i_clk);
            end
            res_ch.ready <= 1'b1;
            @(posedge i_clk);
            while (!(res_ch.valid === 1'b1 && res_ch.ready === 1'b1)) @(posedge i_clk);
        end
    end

    // entered and left at a falling edge
    task automatic send_byte(input logic [7:0] b, input logic fb, input logic cf,
                             input logic lb);
        int unsigned gap;
        gap = idle_en ? $urandom_range(0, 6) : 0;
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.data_byte   <= b;
        in_ch.first_byte  <= fb;
        in_ch.clear_frame <= cf;
        in_ch.last_byte   <= lb;
        @(posedge i_clk);
        while (in_ch.ready !== 1'b1) @(posedge i_clk);
        @(negedge i_clk);
        bytes_sent++;
    endtask

    function automatic void add_text(string s);
        for (int i = 0; i < s.len(); i++) chunk_bytes.push_back(s[i]);
    endfunction

    task automatic send_chunk(input logic clr, input logic mark_first, input logic mark_last,
                              input logic scatter);
        logic fb;
        logic cf;
        logic lb;
        int   last_idx;
        last_idx = chunk_bytes.size() - 1;
        foreach (chunk_bytes[i]) begin
            fb = (i == 0) ? mark_first : (scatter && $urandom_range(0, 59) == 0);
            lb = (i == last_idx) ? mark_last : (scatter && $urandom_range(0, 59) == 0);
            cf = fb ? clr : (scatter && $urandom_range(0, 7) == 0);
            send_byte(chunk_bytes[i], fb, cf, lb);
        end
    endtask

    function automatic string dec_field(int unsigned top);
        case ($urandom_range(0, 29))
            0:  return "";
            1:  return $sformatf("%0d", top + $urandom_range(0, 60));
            2:  return "99999999";
            3:  return "-0";
            4:  return $sformatf("-%0d", $urandom_range(1, 70000));
            5:  return $sformatf("+%0d", $urandom_range(0, top - 1));
            6:  return $sformatf(" \t\n%0d", $urandom_range(0, top - 1));
            7:  return $sformatf("%0d%s", $urandom_range(0, top - 1), "q5");
            8:  return $sformatf("00%0d", $urandom_range(0, top - 1));
            9:  return "z";
            10: return "65536";
            11: return $sformatf("%0d", top - 1);
            default: return $sformatf("%0d", $urandom_range(0, top - 1));
        endcase
    endfunction

    function automatic string colour_field();
        string       hexset;
        string       digits;
        int unsigned len;
        int unsigned idx;
        hexset = "0123456789abcdefABCDEF";
        digits = "";
        len = ($urandom_range(0, 4) == 0) ? $urandom_range(7, 11) : $urandom_range(1, 6);
        if ($urandom_range(0, 9) == 0) len = 0;
        repeat (len) begin
            idx    = $urandom_range(0, 21);
            digits = {digits, hexset.substr(idx, idx)};
        end
        case ($urandom_range(0, 11))
            0: return digits;
            1: return {"0x", digits};
            2: return {"#0X", digits};
            3: return {"#-", digits};
            4: return {"-0x", digits};
            5: return {"#+", digits};
            6: return {"# \t", digits};
            7: return {"#", digits, "g7"};
            8: return {"##", digits};
            9: return {"0", digits};
            default: return {"#", digits};
        endcase
    endfunction

    function automatic void add_group();
        string body;
        body = {dec_field(pcp_pkg::ROWS), ",", dec_field(pcp_pkg::COLUMNS), ",",
                colour_field()};
        case ($urandom_range(0, 15))
            0: body = {dec_field(pcp_pkg::ROWS), ",", dec_field(pcp_pkg::COLUMNS)};
            // pushes part of the useful text past the group character limit
            1: body = {"                        ", body};
            2: body = {"7,(", body};
            3: body = {body, ",1,2"};
            4: body = {body, "0123456789abcdef0123456789"};
            default: ;
        endcase
        add_text({"(", body, ")"});
    endfunction

    function automatic void build_chunk();
        int unsigned groups;
        chunk_bytes.delete();
        if ($urandom_range(0, 4) == 0) add_text("ab(1,2,3)])");
        if ($urandom_range(0, 19) == 0) chunk_bytes.push_back(pcp_pkg::CH_NUL);
        add_text("[");
        groups = $urandom_range(0, 3);
        repeat (groups) begin
            if ($urandom_range(0, 5) == 0) add_text(")");
            if ($urandom_range(0, 5) == 0) add_text(" ,");
            add_group();
        end
        if ($urandom_range(0, 14) == 0) begin
            chunk_bytes.push_back(pcp_pkg::CH_NUL);
            add_group();
        end
        if ($urandom_range(0, 7) == 0) add_text("(1,2,");
        if ($urandom_range(0, 4) != 0) add_text("]");
        if ($urandom_range(0, 5) == 0) add_group();
    endfunction

    function automatic void build_noise();
        string       charset;
        int unsigned len;
        charset = "[]()#,-+0x9 aF\t";
        chunk_bytes.delete();
        len = $urandom_range(1, 10);
        repeat (len) begin
            if ($urandom_range(0, 1) == 0)
                chunk_bytes.push_back(charset[$urandom_range(0, charset.len() - 1)]);
            else
                chunk_bytes.push_back(8'($urandom_range(0, 255)));
        end
    endfunction

    task automatic test_field_extremes();
        chunk_bytes.delete();
        add_text("[(0,-0,0)(15,63,#-1))]");
        send_chunk(1'b1, 1'b1, 1'b1, 1'b0);
    endtask

    task automatic test_chunk_marks();
        // zero byte ahead of the bracket keeps the whole chunk closed
        chunk_bytes.delete();
        chunk_bytes.push_back(8'hFF);
        chunk_bytes.push_back(pcp_pkg::CH_NUL);
        chunk_bytes.push_back(pcp_pkg::CH_OPEN_SQ);
        send_chunk(1'b1, 1'b1, 1'b1, 1'b0);
        // clear without a first mark is dropped, chunks without one still parse
        send_byte(pcp_pkg::CH_CLOSE_SQ, 1'b0, 1'b1, 1'b1);
        send_byte(pcp_pkg::CH_OPEN_SQ, 1'b0, 1'b0, 1'b0);
        send_byte(pcp_pkg::CH_CLOSE_SQ, 1'b0, 1'b0, 1'b1);
    endtask

    task automatic test_random_traffic();
        int unsigned start_count;
        start_count = bytes_sent;
        while (bytes_sent - start_count < RANDOM_ITEMS) begin
            if ($urandom_range(0, 9) == 0) idle_en = ~idle_en;
            if ($urandom_range(0, 6) == 0) build_noise();
            else build_chunk();
            send_chunk(1'($urandom_range(0, 1)), $urandom_range(0, 9) != 0,
                       $urandom_range(0, 9) != 0, 1'b1);
        end
        idle_en = 1'b1;
    endtask

    initial begin
        i_rst_n           = 1'b0;
        in_ch.valid       = 1'b0;
        in_ch.data_byte   = 8'd0;
        in_ch.first_byte  = 1'b0;
        in_ch.clear_frame = 1'b0;
        in_ch.last_byte   = 1'b0;
        idle_en           = 1'b1;
        bytes_sent        = 0;
        fail_count        = 0;
        quiet_cycles      = 0;
        clear_parse();
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_field_extremes();
        test_chunk_marks();
        test_random_traffic();

        in_ch.valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("tb_pixel_command_parser passed");
        end else begin
            $display("tb_pixel_command_parser failed");
        end
        $finish;
    end

endmodule

FILE: filelist.f
rtl/core/pcp_pkg.sv
rtl/core/pcp_if.sv
rtl/core/pixel_command_parser.sv
test/tb_pixel_command_parser.sv
